### design/oks_pkg.sv
// ----------------------------------------------------------------------------
// oks_pkg
// Shared constants, command codes and cell control type for the ordered key set.
// ----------------------------------------------------------------------------
package oks_pkg;

    localparam int CAPACITY    = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 2;
    localparam int IN_FIELDS_W = CMD_W + KEY_WIDTH;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic sample;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

### design/ordered_key_set.sv
// ----------------------------------------------------------------------------
// ordered_key_set
// Sorted set of distinct signed keys held in a row of compare-and-shift cells.
// The first step compares the key in every cell, the second shifts the row
// and registers the result; a new request is taken only after the last one
// has been applied. A stalled result holds only the second step.
// Synchronous active-low reset empties the set; cell keys are not cleared.
// ----------------------------------------------------------------------------
module ordered_key_set (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [1:0] command, [33:2] key, upper bits zero
    input  logic [oks_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] ok, [1] full_res, [10:2] count, upper bits zero
    output logic [oks_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import oks_pkg::*;

    logic                        r_busy;
    t_cmd                        r_cmd;
    logic signed [KEY_WIDTH-1:0] r_req_key;
    logic [CNT_W-1:0]            r_count;
    logic                        r_out_valid;
    logic                        r_ok;
    logic                        r_full;
    logic [CNT_W-1:0]            r_out_count;

    logic                        accept;
    logic                        apply;
    logic                        hit;
    logic                        is_full;
    logic                        do_ins;
    logic                        do_del;
    logic                        n_ok;
    logic                        n_full;
    logic [CNT_W-1:0]            n_count;
    logic signed [KEY_WIDTH-1:0] in_key;
    t_cmd                        in_cmd;
    t_cell_ctl                   ctl;

    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]         cell_lt;
    logic [CAPACITY-1:0]         cell_eq;

    assign in_cmd  = t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
    assign in_key  = i_s_axis_tdata[CMD_W +: KEY_WIDTH];
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign apply   = r_busy && (!r_out_valid || i_m_axis_tready);
    assign hit     = |cell_eq;
    assign is_full = (r_count == CNT_W'(CAPACITY));
    assign do_ins  = apply && (r_cmd == CMD_INSERT) && !hit && !is_full;
    assign do_del  = apply && (r_cmd == CMD_ERASE) && hit;

    assign ctl.sample = accept;
    assign ctl.ins    = do_ins;
    assign ctl.del    = do_del;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                        prev_lt;
            logic signed [KEY_WIDTH-1:0] prev_key;
            logic signed [KEY_WIDTH-1:0] next_key;
            if (g == 0) begin : g_first
                assign prev_lt  = 1'b1;
                assign prev_key = r_req_key;
            end else begin : g_mid
                assign prev_lt  = cell_lt[g-1];
                assign prev_key = cell_key[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign next_key = cell_key[g];
            end else begin : g_body
                assign next_key = cell_key[g+1];
            end
            oks_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_valid    (r_count > CNT_W'(g)),
                .i_probe    (in_key),
                .i_new_key  (r_req_key),
                .i_prev_lt  (prev_lt),
                .i_prev_key (prev_key),
                .i_next_key (next_key),
                .o_key      (cell_key[g]),
                .o_lt       (cell_lt[g]),
                .o_eq       (cell_eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_ok    = 1'b0;
        n_full  = 1'b0;
        n_count = r_count;
        case (r_cmd)
            CMD_FIND: begin
                n_ok = hit;
            end
            CMD_INSERT: begin
                n_ok   = hit || !is_full;
                n_full = !hit && is_full;
                if (!hit && !is_full) begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_ERASE: begin
                n_ok = hit;
                if (hit) begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (apply) begin
                r_busy <= 1'b0;
            end
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= in_cmd;
            r_req_key <= in_key;
        end
        if (apply) begin
            r_ok        <= n_ok;
            r_full      <= n_full;
            r_out_count <= n_count;
        end
    end

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                              r_out_count, r_full, r_ok};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_count_moves_on_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !apply |=> $stable(r_count))
        else $error("key count changed without a request");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_full) |-> (r_out_count == CNT_W'(CAPACITY)))
        else $error("full flag with room left");

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_m_axis_tready) && !r_busy |=> !r_out_valid)
        else $error("result without a request");

endmodule

### design/oks_cell.sv
// ----------------------------------------------------------------------------
// oks_cell
// One slot of the sorted key row: compares against the request key and shifts
// toward either neighbor on insert or erase.
// ----------------------------------------------------------------------------
module oks_cell (
    input  logic                        i_clk,
    input  oks_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_valid,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] i_probe,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] i_new_key,
    input  logic                        i_prev_lt,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] i_prev_key,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] i_next_key,
    output logic signed [oks_pkg::KEY_WIDTH-1:0] o_key,
    output logic                        o_lt,
    output logic                        o_eq
);
    import oks_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_key;
    logic                        r_lt;
    logic                        r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample) begin
            r_lt <= i_valid && (r_key < i_probe);
            r_eq <= i_valid && (r_key == i_probe);
        end
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_new_key : i_prev_key;
        end else if (i_ctl.del && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_key_set. A sorted key queue predicts the
// ok, full_res and count of every request; results are matched in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oks_pkg::*;

    typedef struct packed {
        logic             ok;
        logic             full_res;
        logic [CNT_W-1:0] count;
    } t_set_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    int          held_keys[$];
    t_set_result pending_results[$];
    int          fail_count = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_gaps_on = 1'b1;
    int          sink_hold = 0;
    int          key_pool[320];

    ordered_key_set uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_set_result apply_set_command(t_cmd cmd, logic [KEY_WIDTH-1:0] key);
        t_set_result res;
        int          k;
        int          pos;
        bit          hit;
        k   = key;
        res = '0;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < k) pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == k);
        case (cmd)
            CMD_CLEAR: begin
                held_keys.delete();
                res.ok = 1'b1;
            end
            CMD_FIND: begin
                res.ok = hit;
            end
            CMD_INSERT: begin
                if (hit) begin
                    res.ok = 1'b1;
                end else if (held_keys.size() >= CAPACITY) begin
                    res.full_res = 1'b1;
                end else begin
                    held_keys.insert(pos, k);
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (hit) begin
                    held_keys.delete(pos);
                    res.ok = 1'b1;
                end
            end
        endcase
        res.count = CNT_W'(held_keys.size());
        return res;
    endfunction

    // hold valid across back-to-back requests; predict at the accepting edge
    task automatic send_request(t_cmd cmd, logic [KEY_WIDTH-1:0] key);
        while (src_gaps_on && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, key, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_set_command(cmd, key));
    endtask

    function automatic t_cmd pick_command(int insert_pct, int erase_pct);
        int r;
        r = $urandom_range(99);
        if (r < 2) return CMD_CLEAR;
        if (r < 2 + insert_pct) return CMD_INSERT;
        if (r < 2 + insert_pct + erase_pct) return CMD_ERASE;
        return CMD_FIND;
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key(int span);
        if ($urandom_range(9) < 8) return key_pool[$urandom_range(span - 1)];
        return $urandom();
    endfunction

    task automatic test_directed();
        send_request(CMD_FIND,   32'h0000_0000);
        send_request(CMD_ERASE,  32'h0000_0000);
        send_request(CMD_CLEAR,  32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0001);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_FIND,   32'h8000_0000);
        send_request(CMD_FIND,   32'h7FFF_FFFF);
        send_request(CMD_FIND,   32'hFFFF_FFFF);
        send_request(CMD_FIND,   32'h0000_0002);
        send_request(CMD_ERASE,  32'h0000_0000);
        send_request(CMD_ERASE,  32'h0000_0000);
        send_request(CMD_FIND,   32'h0000_0000);
        send_request(CMD_ERASE,  32'h7FFF_FFFF);
        send_request(CMD_CLEAR,  32'hA5A5_A5A5);
        send_request(CMD_FIND,   32'h0000_0001);
        send_request(CMD_CLEAR,  32'h0000_0000);
        send_request(CMD_INSERT, 32'h5A5A_5A5A);
        send_request(CMD_INSERT, 32'hA5A5_A5A5);
    endtask

    // fill with distinct keys (even low bit) in scrambled order, then overflow
    task automatic test_fill_to_capacity();
        logic [KEY_WIDTH-1:0] fill_keys[CAPACITY];
        int                   idx;
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        send_request(CMD_CLEAR, $urandom());
        for (int i = 0; i < CAPACITY; i++) begin
            fill_keys[i] = {i[7:0], 23'($urandom()), 1'b0};
        end
        for (int i = 0; i < CAPACITY; i++) begin
            idx = (i * 97) % CAPACITY;
            send_request(CMD_INSERT, fill_keys[idx]);
        end
        send_request(CMD_INSERT, {8'h00, 23'($urandom()), 1'b1});
        send_request(CMD_INSERT, fill_keys[17]);
        send_request(CMD_FIND,   fill_keys[0]);
        send_request(CMD_FIND,   fill_keys[CAPACITY - 1]);
        send_request(CMD_ERASE,  fill_keys[128]);
        send_request(CMD_INSERT, {8'h80, 23'($urandom()), 1'b1});
        send_request(CMD_INSERT, {8'h7F, 23'($urandom()), 1'b1});
        send_request(CMD_ERASE,  {8'h11, 23'($urandom()), 1'b1});
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        send_request(CMD_CLEAR,  fill_keys[3]);
    endtask

    // stall the result side while requests keep coming
    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        sink_hold   = 120;
        for (int i = 0; i < 24; i++) begin
            send_request(pick_command(40, 25), pick_key(32));
        end
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        for (int i = 0; i < 500; i++) begin
            send_request(pick_command(35, 30), pick_key(40));
        end
        for (int i = 0; i < 500; i++) begin
            send_request(pick_command(50, 25), pick_key(320));
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(sink_gaps_on && $urandom_range(99) < 29);
        end
    end

    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[0] !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_m_axis_tdata[0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[1] !== want.full_res) begin
                    $error("full_res: expected %0d, got %0d", want.full_res,
                           o_m_axis_tdata[1]);
                    fail_count++;
                end
                if (o_m_axis_tdata[2 +: CNT_W] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count,
                           o_m_axis_tdata[2 +: CNT_W]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 320; i++) key_pool[i] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_to_capacity();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
